// ===== rtl/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, arithmetic constants, sector codes and the request type that
// passes from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Field widths
  localparam int unsigned HueW   = 9;
  localparam int unsigned PctW   = 7;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SectW  = 4;
  localparam int unsigned KW     = 6;
  localparam int unsigned VsW    = 14;
  localparam int unsigned NumW   = 20;
  localparam int unsigned ScaleW = 24;
  localparam int unsigned TW     = 18;
  localparam int unsigned RecipW = 17;
  localparam int unsigned ProdW  = TW + RecipW;

  // Hue geometry: one sector spans 60 degrees, one hue period 120 degrees
  localparam int unsigned HueStep   = 60;
  localparam int unsigned NumThresh = (2 ** HueW - 1) / HueStep;
  localparam logic [HueW-1:0] HUE_PERIOD = HueW'(2 * HueStep);
  localparam logic [PctW-1:0] HM_PERIOD  = PctW'(2 * HueStep);

  // Percent clamp
  localparam logic [PctW-1:0] PCT_MAX = PctW'(100);

  // Numerators over 600000: C = V*S*60, m = V*6000 - C
  localparam logic [NumW-1:0] CHROMA_MUL = NumW'(60);
  localparam logic [NumW-1:0] VALUE_MUL  = NumW'(6000);

  // 255/600000 = 17/40000 = 17 / (64 * 625)
  localparam logic [ScaleW-1:0] SCALE_MUL   = ScaleW'(17);
  localparam int unsigned       ScaleShift  = 6;
  localparam int unsigned       Divisor     = 625;
  localparam int unsigned       RecipShift  = 26;
  localparam logic [RecipW-1:0] RECIP_MUL   = RecipW'((2 ** RecipShift) / Divisor);
  localparam logic [TW-1:0]     DIVISOR_T   = TW'(Divisor);

  // Sector codes (hue / 60); codes above the last one select no channel
  localparam logic [SectW-1:0] SECT_RED_YEL = SectW'(0);
  localparam logic [SectW-1:0] SECT_YEL_GRN = SectW'(1);
  localparam logic [SectW-1:0] SECT_GRN_CYN = SectW'(2);
  localparam logic [SectW-1:0] SECT_CYN_BLU = SectW'(3);
  localparam logic [SectW-1:0] SECT_BLU_MAG = SectW'(4);
  localparam logic [SectW-1:0] SECT_MAG_RED = SectW'(5);

  // Classified request held in the queue
  typedef struct packed {
    logic [SectW-1:0] sector;
    logic [KW-1:0]    k;
    logic [PctW-1:0]  v;
    logic [VsW-1:0]   vs;
  } item_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

// ===== rtl/hsv2rgb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Clamps saturation and value, finds the hue sector and the intermediate
// weight, and forms the value-saturation product for the queue.
// ----------------------------------------------------------------------------
module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic [HueW-1:0] hue_i,
  input  logic [PctW-1:0] saturation_i,
  input  logic [PctW-1:0] brightness_i,
  output item_t           item_o
);

  logic [PctW-1:0]  sat;
  logic [PctW-1:0]  val;
  logic [SectW-1:0] sector;
  logic [HueW-1:0]  hue_base;
  logic [PctW-1:0]  hm;

  // Clamp percentages to 100
  always_comb begin
    sat = (saturation_i > PCT_MAX) ? PCT_MAX : saturation_i;
    val = (brightness_i > PCT_MAX) ? PCT_MAX : brightness_i;
  end

  // Count sector thresholds passed by the hue
  always_comb begin
    sector = '0;
    for (int i = 1; i <= NumThresh; i++) begin
      if (hue_i >= HueW'(i * HueStep)) begin
        sector = sector + SectW'(1);
      end
    end
  end

  // Reduce hue modulo 120 and fold it into the weight 60 - |hm - 60|
  always_comb begin
    hue_base = HueW'({{(HueW-SectW+1){1'b0}}, sector[SectW-1:1]} * HUE_PERIOD);
    hm       = PctW'(hue_i - hue_base);
    item_o.sector = sector;
    item_o.k      = sector[0] ? KW'(HM_PERIOD - hm) : KW'(hm);
    item_o.v      = val;
    item_o.vs     = VsW'({{(VsW-PctW){1'b0}}, val} * {{(VsW-PctW){1'b0}}, sat});
  end

endmodule
`default_nettype wire

// ===== rtl/hsv2rgb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB request queue
// Small circular buffer between the front and back ends, so that each side
// can stall without holding up the other. Depth must be at least two.
// ----------------------------------------------------------------------------
module hsv2rgb_queue import hsv2rgb_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  item_t         item_i,
  input  logic          pop_i,
  output item_t         item_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  // Occupancy flags
  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store incoming request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hsv2rgb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB back end
// Four-stage pipeline: channel numerators, scale by 17/64, reciprocal
// estimate of the division by 625, then one correction into the output
// register.
// ----------------------------------------------------------------------------
module hsv2rgb_back import hsv2rgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  logic             avail_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  logic v1_q, v2_q, v3_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy_out;

  logic [NumW-1:0]            chroma, inter, offset;
  logic [NumW-1:0]            comp [3];
  logic [2:0][NumW-1:0]       num_d, num_q;
  logic [2:0][TW-1:0]         t2_d, t2_q;
  logic [2:0][TW-1:0]         t3_q;
  logic [2:0][ChanW-1:0]      qe_d, qe_q;
  logic [2:0][ChanW-1:0]      chan_d, chan_q;
  logic [ProdW-1:0]           prod [3];
  logic [ScaleW-1:0]          scaled [3];
  logic [TW-1:0]              rem [3];

  // Ready chain from the output register backwards
  assign rdy_out     = !out_valid_q || !out_stall_i;
  assign rdy3        = !v3_q || rdy_out;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign pop_o       = avail_i && rdy1;
  assign out_valid_o = out_valid_q;
  assign red_o       = chan_q[0];
  assign green_o     = chan_q[1];
  assign blue_o      = chan_q[2];

  // Stage one: chroma, intermediate, offset and sector routing
  always_comb begin
    chroma = {{(NumW-VsW){1'b0}}, item_i.vs} * CHROMA_MUL;
    inter  = {{(NumW-VsW){1'b0}}, item_i.vs} * {{(NumW-KW){1'b0}}, item_i.k};
    offset = {{(NumW-PctW){1'b0}}, item_i.v} * VALUE_MUL - chroma;
    comp[0] = '0;
    comp[1] = '0;
    comp[2] = '0;
    case (item_i.sector)
      SECT_RED_YEL: begin comp[0] = chroma; comp[1] = inter;  end
      SECT_YEL_GRN: begin comp[0] = inter;  comp[1] = chroma; end
      SECT_GRN_CYN: begin comp[1] = chroma; comp[2] = inter;  end
      SECT_CYN_BLU: begin comp[1] = inter;  comp[2] = chroma; end
      SECT_BLU_MAG: begin comp[0] = inter;  comp[2] = chroma; end
      SECT_MAG_RED: begin comp[0] = chroma; comp[2] = inter;  end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      num_d[i] = comp[i] + offset;
    end
  end

  // Stages two to four per channel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scaled[i] = {{(ScaleW-NumW){1'b0}}, num_q[i]} * SCALE_MUL;
      t2_d[i]   = TW'(scaled[i] >> ScaleShift);
      prod[i]   = {{RecipW{1'b0}}, t2_q[i]} * {{TW{1'b0}}, RECIP_MUL};
      qe_d[i]   = prod[i][RecipShift +: ChanW];
      rem[i]    = t3_q[i] - TW'({{(TW-ChanW){1'b0}}, qe_q[i]} * DIVISOR_T);
      chan_d[i] = (rem[i] >= DIVISOR_T) ? qe_q[i] + ChanW'(1) : qe_q[i];
    end
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q        <= avail_i;
      if (rdy2)    v2_q        <= v1_q;
      if (rdy3)    v3_q        <= v2_q;
      if (rdy_out) out_valid_q <= v3_q;
    end
  end

  // Advance stage payloads; hold while stalled
  always_ff @(posedge clk_i) begin
    if (rdy1) num_q <= num_d;
    if (rdy2) t2_q  <= t2_d;
    if (rdy3) begin
      t3_q <= t2_q;
      qe_q <= qe_d;
    end
    if (rdy_out) chan_q <= chan_d;
  end

endmodule
`default_nettype wire

// ===== rtl/hsv_to_rgb_converter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB converter, top level
// Converts one hue/saturation/value pixel per clock while not stalled into
// 8-bit red, green and blue.
// ----------------------------------------------------------------------------
// The converter takes one request per clock while in_stall_o is low and
// returns one RGB result per request, in order. A request is classified
// (clamp, sector, hue weight, value-saturation product) as it is accepted and
// written into a queue of QueueDepth entries; a four-stage back-end pipeline
// reads the queue and holds the result in an output register. With the output
// not stalled, throughput is one request per clock, set by the fully
// pipelined back end. Saturation and value above 100 are clamped to 100; hues
// from 360 up give grey at the offset level. in_stall_o rises only once the
// queue is full.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top import hsv2rgb_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [HueW-1:0]  hue_i,
  input  logic [PctW-1:0]  saturation_i,
  input  logic [PctW-1:0]  brightness_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  item_t         front_item;
  item_t         head_item;
  queue_status_t q_status;
  logic          pop;

  // Classify the incoming request
  hsv2rgb_front u_front (
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .item_o       (front_item)
  );

  // Decouple front and back ends
  hsv2rgb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_valid_i),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  assign in_stall_o = q_status.full;

  // Compute the channels
  hsv2rgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .avail_i     (!q_status.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule
`default_nettype wire

// ===== rtl/hsv2rgb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB port checker
// Watches the top-level ports for output hold and queue back-pressure
// behaviour.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [8:0] hue_i,
  input logic [6:0] saturation_i,
  input logic [6:0] brightness_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("stalled result changed or dropped");

  // Fill the queue only behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // Release the input once the output drains
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after output drained");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives hue/saturation/value requests through the valid/stall input channel.
// Every result from the output channel is checked, channel by channel and in
// order, against a hand-typed colour or a behavioural conversion model held
// here. A short directed table covers the primaries, greys, sector edges,
// clamping and hues above 359. A random part follows, mostly in-range
// colours, with out-of-range values and hues. Both channels pause at random.
// ----------------------------------------------------------------------------
module tb_top;
  import hsv2rgb_pkg::*;

  // Common denominator of the exact arithmetic: 100 * 100 * 60
  localparam int unsigned FracDenom  = 600000;
  localparam int unsigned RandItems  = 450;
  localparam int unsigned DirRows    = 25;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 12;
  localparam int unsigned MaxPrints  = 200;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] bri;
    logic            typed;
    rgb_t            rgb;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [HueW-1:0]  hue_i = '0;
  logic [PctW-1:0]  saturation_i = '0;
  logic [PctW-1:0]  brightness_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;

  // Expected colour of the request on the input port, where typed by hand
  logic             cur_typed = 1'b0;
  rgb_t             cur_rgb = '0;

  rgb_t             rgb_expected[$];
  stim_row_t        dir_table[DirRows];
  int unsigned      n_errors = 0;
  int unsigned      n_requests = 0;
  int unsigned      n_results = 0;
  int unsigned      n_odd = 0;
  int unsigned      cycle_cnt = 0;
  bit               send_quiet = 1'b0;

  hsv_to_rgb_converter_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Convert one colour with exact fractions over FracDenom
  function automatic rgb_t hsv_to_rgb_calc(logic [HueW-1:0] h, logic [PctW-1:0] s_in,
                                           logic [PctW-1:0] v_in);
    int unsigned      s, v, vs, chroma, mid, offs, hm, wgt;
    int unsigned      rn, gn, bn;
    logic [SectW-1:0] sect;
    rgb_t             res;
    s = (s_in > PCT_MAX) ? 100 : int'(s_in);
    v = (v_in > PCT_MAX) ? 100 : int'(v_in);
    vs = v * s;
    chroma = vs * 60;
    hm = int'(h) % 120;
    wgt = (hm >= 60) ? (120 - hm) : hm;
    mid = vs * wgt;
    offs = v * 6000 - chroma;
    sect = SectW'(int'(h) / 60);
    rn = 0;
    gn = 0;
    bn = 0;
    case (sect)
      SECT_RED_YEL: begin rn = chroma; gn = mid;    end
      SECT_YEL_GRN: begin rn = mid;    gn = chroma; end
      SECT_GRN_CYN: begin gn = chroma; bn = mid;    end
      SECT_CYN_BLU: begin gn = mid;    bn = chroma; end
      SECT_BLU_MAG: begin rn = mid;    bn = chroma; end
      SECT_MAG_RED: begin rn = chroma; bn = mid;    end
      default: ;
    endcase
    res.red   = ChanW'((255 * (rn + offs)) / FracDenom);
    res.green = ChanW'((255 * (gn + offs)) / FracDenom);
    res.blue  = ChanW'((255 * (bn + offs)) / FracDenom);
    return res;
  endfunction

  // Print one line per mismatch, up to a cap, and count all of them
  task automatic report_mismatch(string what, rgb_t got, rgb_t want);
    n_errors++;
    if (n_errors <= MaxPrints) begin
      $display("ERROR @%0t result %0d: %s got r=%0d g=%0d b=%0d want r=%0d g=%0d b=%0d",
               $time, n_results, what, got.red, got.green, got.blue,
               want.red, want.green, want.blue);
    end
  endtask

  // Cycle counter and run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("hsv_to_rgb_converter_top: mismatch");
      $finish;
    end
  end

  // Output stall: raised at random with a chance of about 16 percent, with one long quiet window
  always @(negedge clk_i) begin
    if (!rst_ni || (cycle_cnt >= 250 && cycle_cnt < 450)) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 16);
    end
  end

  // Record accepted requests and check accepted results against the oldest one
  always @(posedge clk_i) begin
    rgb_t got;
    rgb_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        n_requests++;
        if (cur_typed) begin
          rgb_expected.push_back(cur_rgb);
        end else begin
          rgb_expected.push_back(hsv_to_rgb_calc(hue_i, saturation_i, brightness_i));
        end
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{red: red_o, green: green_o, blue: blue_o};
        n_results++;
        if (rgb_expected.size() == 0) begin
          report_mismatch("unexpected result", got, '0);
        end else begin
          want = rgb_expected.pop_front();
          if (got.red !== want.red)     report_mismatch("red", got, want);
          if (got.green !== want.green) report_mismatch("green", got, want);
          if (got.blue !== want.blue)   report_mismatch("blue", got, want);
        end
      end
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(logic [HueW-1:0] h, logic [PctW-1:0] s, logic [PctW-1:0] v,
                              logic typed, rgb_t rgb);
    bit taken;
    while (!send_quiet && $urandom_range(0, 99) < 16) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    hue_i = h;
    saturation_i = s;
    brightness_i = v;
    cur_typed = typed;
    cur_rgb = rgb;
    in_valid_i = 1'b1;
    if (s > PCT_MAX || v > PCT_MAX || h >= HUE_PERIOD * 3) n_odd++;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = in_valid_i && !in_stall_o;
    end
    @(negedge clk_i);
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (rgb_expected.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [HueW-1:0] h;
    logic [PctW-1:0] s;
    logic [PctW-1:0] v;
    int unsigned     pick;

    // hue, saturation, brightness, typed, expected colour
    dir_table = '{
      '{9'd0,   7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{9'd0,   7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{9'd60,  7'd100, 7'd100, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{9'd120, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0}},
      '{9'd180, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd255}},
      '{9'd240, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255}},
      '{9'd300, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd255}},
      '{9'd0,   7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{9'd60,  7'd100, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{9'd359, 7'd100, 7'd100, 1'b0, '0},
      '{9'd30,  7'd100, 7'd100, 1'b0, '0},
      '{9'd90,  7'd50,  7'd75,  1'b0, '0},
      '{9'd150, 7'd100, 7'd50,  1'b0, '0},
      '{9'd210, 7'd25,  7'd100, 1'b0, '0},
      '{9'd270, 7'd80,  7'd80,  1'b0, '0},
      '{9'd330, 7'd60,  7'd40,  1'b0, '0},
      '{9'd119, 7'd99,  7'd99,  1'b0, '0},
      '{9'd359, 7'd1,   7'd1,   1'b0, '0},
      // saturation and value above 100 clamp to 100
      '{9'd0,   7'd127, 7'd127, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{9'd200, 7'd101, 7'd100, 1'b0, '0},
      '{9'd100, 7'd100, 7'd127, 1'b0, '0},
      // hues from 360 up select no channel: grey at the offset level
      '{9'd360, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd0}},
      '{9'd400, 7'd50,  7'd100, 1'b1, '{8'd127, 8'd127, 8'd127}},
      '{9'd511, 7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{9'd511, 7'd127, 7'd127, 1'b1, '{8'd0,   8'd0,   8'd0}}
    };

    // Hold reset low, then release it
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (dir_table[i]) begin
      send_request(dir_table[i].hue, dir_table[i].sat, dir_table[i].bri,
                   dir_table[i].typed, dir_table[i].rgb);
    end
    drain_results();

    // Random colours: mostly in range, some edges and out-of-range values
    for (int unsigned n = 0; n < RandItems; n++) begin
      send_quiet = (n >= 150 && n < 260);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        h = HueW'($urandom_range(0, 359));
        s = PctW'($urandom_range(0, 100));
        v = PctW'($urandom_range(0, 100));
      end else if (pick < 80) begin
        h = HueW'($urandom_range(0, 6) * 60 + $urandom_range(0, 2)) - 1'b1;
        if (h > 359) h = 0;
        s = $urandom_range(0, 1) ? PCT_MAX : PctW'($urandom_range(0, 1));
        v = $urandom_range(0, 1) ? PCT_MAX : PctW'($urandom_range(0, 1));
      end else if (pick < 90) begin
        h = HueW'($urandom_range(0, 359));
        s = PctW'($urandom_range(0, 127));
        v = PctW'($urandom_range(0, 127));
      end else begin
        h = HueW'($urandom_range(360, 511));
        s = PctW'($urandom_range(0, 127));
        v = PctW'($urandom_range(0, 127));
      end
      send_request(h, s, v, 1'b0, '0);
      if (n == RandItems / 2) drain_results();
    end
    send_quiet = 1'b0;
    in_valid_i = 1'b0;

    // Wait for the last results, then let the pipeline settle
    while (rgb_expected.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (rgb_expected.size() != 0) begin
      report_mismatch("missing result", '0, rgb_expected[0]);
    end

    $display("covered %0d requests (%0d with out-of-range fields), %0d results checked",
             n_requests, n_odd, n_results);
    $display("primaries, greys, sector edges, clamping and hues above 359 exercised");
    if (n_errors == 0) begin
      $display("hsv_to_rgb_converter_top: match");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("hsv_to_rgb_converter_top: mismatch");
    end
    $finish;
  end

endmodule
